[sv/fac_pkg.sv]
package fac_pkg;

	localparam int PLANE_COUNT    = 6;
	localparam int PLANE_W        = 64;
	localparam int NRM_W          = 16;
	localparam int DIST_W         = 16;
	localparam int DIST_SHIFT     = 14;
	localparam int CFG_IDX_W      = 3;
	localparam int DEF_COORD_BITS = 16;
	localparam int NUM_COORDS     = 6;

	// box word layout: min x,y,z at 0..2, max x,y,z at 3..5
	localparam int MIN_BASE = 0;
	localparam int MAX_BASE = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		PL_NEAR   = 3'd0,
		PL_FAR    = 3'd1,
		PL_LEFT   = 3'd2,
		PL_RIGHT  = 3'd3,
		PL_TOP    = 3'd4,
		PL_BOTTOM = 3'd5
	} plane_idx_t;

	typedef enum logic [1:0] {
		CLS_DISJOINT   = 2'd0,
		CLS_INTERSECTS = 2'd1,
		CLS_CONTAINS   = 2'd2
	} cont_t;

	typedef struct packed {
		logic any_p;
		logic any_n;
	} hit_t;

endpackage

[sv/fac_box_if.sv]
interface fac_box_if import fac_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] min_x;
	logic signed [COORD_BITS-1:0] min_y;
	logic signed [COORD_BITS-1:0] min_z;
	logic signed [COORD_BITS-1:0] max_x;
	logic signed [COORD_BITS-1:0] max_y;
	logic signed [COORD_BITS-1:0] max_z;

	modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
	modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

[sv/fac_cls_if.sv]
interface fac_cls_if import fac_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] containment;

	modport source (output valid, containment, input ready);
	modport sink (input valid, containment, output ready);
endinterface

[sv/fac_cell.sv]
module fac_cell import fac_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  plane_we,
	input  logic [PLANE_W-1:0]                    plane_data,
	input  logic                                  up_valid,
	output logic                                  up_ready,
	input  logic [NUM_COORDS-1:0][COORD_BITS-1:0] up_box,
	input  hit_t                                  up_hit,
	output logic                                  dn_valid,
	input  logic                                  dn_ready,
	output logic [NUM_COORDS-1:0][COORD_BITS-1:0] dn_box,
	output hit_t                                  dn_hit
);

	localparam int PROD_W = NRM_W + COORD_BITS;
	localparam int DSC_W  = DIST_W + DIST_SHIFT;
	localparam int ACC_W  = ((PROD_W > DSC_W) ? PROD_W : DSC_W) + 2;

	logic [PLANE_W-1:0] plane_q;

	logic signed [NRM_W-1:0]      nrm [3];
	logic signed [COORD_BITS-1:0] pv [3];
	logic signed [COORD_BITS-1:0] nv [3];
	logic signed [PROD_W-1:0]     pp [3];
	logic signed [PROD_W-1:0]     pn [3];

	logic                                  v_s1;
	logic [NUM_COORDS-1:0][COORD_BITS-1:0] box_s1;
	hit_t                                  hit_s1;
	logic signed [PROD_W-1:0]              pp_s1 [3];
	logic signed [PROD_W-1:0]              pn_s1 [3];
	logic signed [DIST_W-1:0]              dist_s1;

	logic                                  v_s2;
	logic [NUM_COORDS-1:0][COORD_BITS-1:0] box_s2;
	hit_t                                  hit_s2;

	logic signed [ACC_W-1:0] acc_p;
	logic signed [ACC_W-1:0] acc_n;
	logic                    rdy_s1;
	logic                    rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (plane_we) begin
			plane_q <= plane_data;
		end
	end

	// p-vertex takes max where the normal component is non-negative
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nrm[k] = signed'(plane_q[k*NRM_W +: NRM_W]);
			if (!nrm[k][NRM_W-1]) begin
				pv[k] = signed'(up_box[MAX_BASE+k]);
				nv[k] = signed'(up_box[MIN_BASE+k]);
			end else begin
				pv[k] = signed'(up_box[MIN_BASE+k]);
				nv[k] = signed'(up_box[MAX_BASE+k]);
			end
			pp[k] = PROD_W'(nrm[k]) * PROD_W'(pv[k]);
			pn[k] = PROD_W'(nrm[k]) * PROD_W'(nv[k]);
		end
	end

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			box_s1  <= up_box;
			hit_s1  <= up_hit;
			dist_s1 <= signed'(plane_q[PLANE_W-1 -: DIST_W]);
			for (int k = 0; k < 3; k++) begin
				pp_s1[k] <= pp[k];
				pn_s1[k] <= pn[k];
			end
		end
	end

	always_comb begin
		acc_p = (ACC_W'(dist_s1) <<< DIST_SHIFT) + ACC_W'(pp_s1[0]) + ACC_W'(pp_s1[1])
			+ ACC_W'(pp_s1[2]);
		acc_n = (ACC_W'(dist_s1) <<< DIST_SHIFT) + ACC_W'(pn_s1[0]) + ACC_W'(pn_s1[1])
			+ ACC_W'(pn_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			box_s2       <= box_s1;
			hit_s2.any_p <= hit_s1.any_p | acc_p[ACC_W-1];
			hit_s2.any_n <= hit_s1.any_n | acc_n[ACC_W-1];
		end
	end

	assign dn_valid = v_s2;
	assign dn_box   = box_s2;
	assign dn_hit   = hit_s2;

endmodule

[sv/frustum_aabb_classify.sv]
// Pipeline: six plane cells, each registering its products, then sum and sign,
// then the output register. Throughput: one box per cycle while the result side
// accepts; every stage moves on when its successor frees.
// Reset: arst_n clears all valid flags and the six plane registers to zero,
// so an unconfigured block reports every box as contained.
module frustum_aabb_classify import fac_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fac_box_if.sink              box,
	fac_cls_if.source            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PLANE_W-1:0]   cfg_data
);

	logic [PLANE_COUNT:0]                  c_valid;
	logic [PLANE_COUNT:0]                  c_ready;
	logic [NUM_COORDS-1:0][COORD_BITS-1:0] c_box [PLANE_COUNT+1];
	hit_t                                  c_hit [PLANE_COUNT+1];

	logic  out_v_q;
	cont_t cont_q;

	assign c_valid[0] = box.valid;
	assign box.ready  = c_ready[0];
	assign c_box[0]   = {box.max_z, box.max_y, box.max_x, box.min_z, box.min_y, box.min_x};
	assign c_hit[0]   = '0;

	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
		fac_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.plane_we   (cfg_we && (cfg_index == CFG_IDX_W'(i))),
			.plane_data (cfg_data),
			.up_valid   (c_valid[i]),
			.up_ready   (c_ready[i]),
			.up_box     (c_box[i]),
			.up_hit     (c_hit[i]),
			.dn_valid   (c_valid[i+1]),
			.dn_ready   (c_ready[i+1]),
			.dn_box     (c_box[i+1]),
			.dn_hit     (c_hit[i+1])
		);
	end

	// output register; the last cell's box word is not needed beyond here
	assign c_ready[PLANE_COUNT] = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (c_ready[PLANE_COUNT]) begin
			out_v_q <= c_valid[PLANE_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[PLANE_COUNT]) begin
			if (c_hit[PLANE_COUNT].any_p)
				cont_q <= CLS_DISJOINT;
			else if (c_hit[PLANE_COUNT].any_n)
				cont_q <= CLS_INTERSECTS;
			else
				cont_q <= CLS_CONTAINS;
		end
	end

	assign result.valid       = out_v_q;
	assign result.containment = cont_q;

endmodule

[sv/fac_checker.sv]
module fac_checker import fac_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] containment
);

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (containment == CLS_DISJOINT || containment == CLS_INTERSECTS
			|| containment == CLS_CONTAINS))
		else $error("containment code out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(containment)))
		else $error("stalled result changed");

	// with the output free, every stage can move, so a box is always taken
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output side was free");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight after reset");

	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

bind frustum_aabb_classify fac_checker u_fac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (box.valid),
	.in_ready    (box.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.containment (result.containment)
);

[test/tb_frustum_aabb_classify.sv]
module tb_frustum_aabb_classify;
	import fac_pkg::*;

	localparam int Q14_ONE         = 16384;     // 1.0 in Q2.14
	localparam int Q4_ONE          = 16;        // 1.0 in Q12.4
	localparam int HALF            = 100 * Q4_ONE;
	localparam int RESET_CYCLES    = 6;
	localparam int SETTLE_CYCLES   = 20;        // pipeline is 13 deep
	localparam int CYCLE_LIMIT     = 900000;
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int PRESSURE_PHASE  = 6;

	typedef logic signed [DEF_COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PLANE_W-1:0]   cfg_data;

	fac_box_if box_ch ();
	fac_cls_if cls_ch ();

	frustum_aabb_classify dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box_ch),
		.result    (cls_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [PLANE_W-1:0] plane_mirror [PLANE_COUNT];
	cont_t              expected_cls [$];

	bit source_gaps;
	bit sink_stalls;
	int mismatches;
	int cycle_count;
	int boxes_sent;
	int results_seen;
	int plane_writes;
	int seen_disjoint;
	int seen_intersects;
	int seen_contains;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [PLANE_W-1:0] plane_word(input int nx, input int ny, input int nz,
			input int d);
		return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
	endfunction

	function automatic box_t box_of(input int x0, input int y0, input int z0,
			input int x1, input int y1, input int z1);
		box_t b;
		b.min_x = coord_t'(x0);
		b.min_y = coord_t'(y0);
		b.min_z = coord_t'(z0);
		b.max_x = coord_t'(x1);
		b.max_y = coord_t'(y1);
		b.max_z = coord_t'(z1);
		return b;
	endfunction

	// p-vertex picks max where the normal component is >= 0, n-vertex the opposite
	function automatic cont_t classify_box(input box_t b);
		longint lo [3];
		longint hi [3];
		longint nrm, offs, acc_p, acc_n;
		logic   any_p, any_n;
		lo[0] = b.min_x;
		lo[1] = b.min_y;
		lo[2] = b.min_z;
		hi[0] = b.max_x;
		hi[1] = b.max_y;
		hi[2] = b.max_z;
		any_p = 1'b0;
		any_n = 1'b0;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			offs  = longint'($signed(plane_mirror[i][PLANE_W-1 -: DIST_W]));
			acc_p = offs * (longint'(1) << DIST_SHIFT);
			acc_n = acc_p;
			for (int k = 0; k < 3; k++) begin
				nrm = longint'($signed(plane_mirror[i][NRM_W*k +: NRM_W]));
				if (nrm >= 0) begin
					acc_p += nrm * hi[k];
					acc_n += nrm * lo[k];
				end else begin
					acc_p += nrm * lo[k];
					acc_n += nrm * hi[k];
				end
			end
			if (acc_p < 0)
				any_p = 1'b1;
			if (acc_n < 0)
				any_n = 1'b1;
		end
		if (any_p)
			return CLS_DISJOINT;
		if (any_n)
			return CLS_INTERSECTS;
		return CLS_CONTAINS;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0d] MISMATCH: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic write_plane(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < PLANE_COUNT)
			plane_mirror[idx] = val;
		plane_writes++;
	endtask

	// valid is left high after a transfer so back-to-back boxes need no extra step
	task automatic send_box(input box_t b);
		int    gap;
		cont_t want;
		gap = (source_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			box_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.min_x <= b.min_x;
		box_ch.min_y <= b.min_y;
		box_ch.min_z <= b.min_z;
		box_ch.max_x <= b.max_x;
		box_ch.max_y <= b.max_y;
		box_ch.max_z <= b.max_z;
		do @(posedge clk); while (!box_ch.ready);
		want = classify_box(b);
		expected_cls.push_back(want);
		boxes_sent++;
		case (want)
			CLS_DISJOINT:   seen_disjoint++;
			CLS_INTERSECTS: seen_intersects++;
			default:        seen_contains++;
		endcase
	endtask

	task automatic drain_results();
		@(negedge clk);
		box_ch.valid <= 1'b0;
		while (expected_cls.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_state();
		// unconfigured planes are all zero: every box is contained
		send_box(box_of(0, 0, 0, 0, 0, 0));
		send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(box_of(32767, 32767, 32767, -32768, -32768, -32768));
		send_box(box_of(-1, 1, -1, 1, -1, 1));
		drain_results();
	endtask

	task automatic test_axis_frustum();
		write_plane(PL_LEFT,   plane_word(Q14_ONE, 0, 0, HALF));
		write_plane(PL_RIGHT,  plane_word(-Q14_ONE, 0, 0, HALF));
		write_plane(PL_BOTTOM, plane_word(0, Q14_ONE, 0, HALF));
		write_plane(PL_TOP,    plane_word(0, -Q14_ONE, 0, HALF));
		write_plane(PL_NEAR,   plane_word(0, 0, Q14_ONE, HALF));
		write_plane(PL_FAR,    plane_word(0, 0, -Q14_ONE, HALF));
		send_box(box_of(-160, -160, -160, 160, 160, 160));
		// faces exactly on the planes still count as inside
		send_box(box_of(-HALF, -HALF, -HALF, HALF, HALF, HALF));
		send_box(box_of(-HALF, -HALF, -HALF, HALF + 1, HALF, HALF));
		send_box(box_of(-3200, -160, -160, 0, 160, 160));
		send_box(box_of(3200, -160, -160, 4800, 160, 160));
		send_box(box_of(-160, -160, -4800, 160, 160, -3200));
		send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(box_of(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(box_of(-32768, -32768, -32768, -32768, -32768, -32768));
		// inverted boxes: corners taken as given, no swap
		send_box(box_of(800, -160, -160, -800, 160, 160));
		send_box(box_of(2400, -160, -160, -2400, 160, 160));
		drain_results();
		// most negative and most positive normal components
		write_plane(PL_LEFT,  plane_word(-32768, 0, 0, 32767));
		write_plane(PL_RIGHT, plane_word(32767, 0, 0, 32767));
		send_box(box_of(-160, -160, -160, 160, 160, 160));
		send_box(box_of(-32768, -160, -160, 32767, 160, 160));
		drain_results();
	endtask

	task automatic test_degenerate_planes();
		sink_stalls = 1'b1;
		write_plane(PL_TOP, '0);
		send_box(box_of(-160, 2400, -160, 160, 3200, 160));
		drain_results();
		// zero normal with negative distance puts everything behind
		write_plane(PL_NEAR, plane_word(0, 0, 0, -1));
		send_box(box_of(-160, -160, -160, 160, 160, 160));
		send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
		drain_results();
		write_plane(PL_NEAR, plane_word(0, 0, Q14_ONE, HALF));
		// indices past the last plane must not land anywhere
		for (int idx = PLANE_COUNT; idx < (1 << CFG_IDX_W); idx++)
			write_plane(CFG_IDX_W'(idx), plane_word(0, 0, 0, -Q4_ONE));
		send_box(box_of(-160, -160, -160, 160, 160, 160));
		drain_results();
		sink_stalls = 1'b0;
	endtask

	task automatic test_random_frustums();
		logic [PLANE_W-1:0] extremes [4];
		int                 c, h, lo_i, hi_i;
		coord_t             lo [3];
		coord_t             hi [3];
		extremes[0] = '0;
		extremes[1] = '1;
		extremes[2] = 64'h7FFF_7FFF_7FFF_7FFF;
		extremes[3] = 64'h8000_8000_8000_8000;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();
			for (int i = 0; i < PLANE_COUNT; i++) begin
				case (phase % 4)
					0, 3: write_plane(CFG_IDX_W'(i), plane_word(
						int'($urandom_range(0, 32768)) - Q14_ONE,
						int'($urandom_range(0, 32768)) - Q14_ONE,
						int'($urandom_range(0, 32768)) - Q14_ONE,
						int'($urandom_range(0, 32767 + 4096)) - 4096));
					1: write_plane(CFG_IDX_W'(i), {$urandom, $urandom});
					default: write_plane(CFG_IDX_W'(i), extremes[(i + phase / 4) % 4]);
				endcase
			end
			if (phase % 4 == 3) begin
				write_plane(CFG_IDX_W'(phase % PLANE_COUNT), '0);
				write_plane(CFG_IDX_W'((phase + 1) % PLANE_COUNT),
					plane_word(0, 0, 0, $urandom_range(0, 32767)));
			end
			source_gaps = (phase % 3 != 0);
			sink_stalls = (phase % 4 >= 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2)
					drain_results();
				if ($urandom_range(0, 3) == 0) begin
					// full-range noise, frequently inverted
					for (int k = 0; k < 3; k++) begin
						lo[k] = coord_t'($urandom_range(0, 65535));
						hi[k] = coord_t'($urandom_range(0, 65535));
					end
				end else begin
					for (int k = 0; k < 3; k++) begin
						c = int'($urandom_range(0, 32768)) - 16384;
						h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16384)
							: $urandom_range(0, 1024);
						lo_i = c - h;
						hi_i = c + h;
						if (lo_i < -32768)
							lo_i = -32768;
						if (hi_i > 32767)
							hi_i = 32767;
						lo[k] = coord_t'(lo_i);
						hi[k] = coord_t'(hi_i);
					end
				end
				send_box(box_of(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
			end
		end
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
	endtask

	// result side: random back-pressure when enabled
	initial begin
		int n;
		cls_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_stalls && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
				cls_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			cls_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cont_t want;
		if (arst_n && cls_ch.valid && cls_ch.ready) begin
			results_seen++;
			if (expected_cls.size() == 0) begin
				report_mismatch($sformatf("containment %0d with nothing outstanding",
					cls_ch.containment));
			end else begin
				want = expected_cls.pop_front();
				if (cls_ch.containment !== want)
					report_mismatch($sformatf("result %0d: containment %0d, want %0d",
						results_seen, cls_ch.containment, want));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_cls.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = PL_NEAR;
		cfg_data     = '0;
		box_ch.valid = 1'b0;
		box_ch.min_x = '0;
		box_ch.min_y = '0;
		box_ch.min_z = '0;
		box_ch.max_x = '0;
		box_ch.max_y = '0;
		box_ch.max_z = '0;
		source_gaps  = 1'b0;
		sink_stalls  = 1'b0;
		for (int i = 0; i < PLANE_COUNT; i++)
			plane_mirror[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_axis_frustum();
		test_degenerate_planes();
		test_random_frustums();
		drain_results();

		$display("%0d boxes classified, %0d results checked, %0d plane writes incl. unused indices",
			boxes_sent, results_seen, plane_writes);
		$display("outcomes: %0d disjoint, %0d intersects, %0d contains",
			seen_disjoint, seen_intersects, seen_contains);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
